/* rtl/msfw_pkg.sv */
// ----------------------------------------------------------------------------
// msfw_pkg
// Shared types and constants for the monochrome span fill writer.
// ----------------------------------------------------------------------------
`default_nettype none

package msfw_pkg;

    localparam int X_W      = 7;
    localparam int ROW_W    = 10;
    localparam int THICK_W  = 3;
    localparam int COLOUR_W = 8;
    localparam int ADDR_W   = 32;
    localparam int PITCH_W  = 8;
    localparam int STRIDE_W = 6;
    localparam int COL_W    = X_W - 3;
    localparam int PROD_W   = ROW_W + STRIDE_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [THICK_W-1:0]  MAX_THICKNESS = 3'd4;
    localparam logic [PITCH_W-1:0]  PITCH_RESET   = 8'd128;
    localparam logic [ADDR_W-1:0]   BASE_RESET    = 32'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_CLEAR  = 8'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_SET    = 8'd1;
    localparam logic [7:0]          BYTE_ONES     = 8'hff;
    localparam logic [7:0]          BYTE_ZEROS    = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_PIXELS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_BASE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic base;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic cmd_ok;
        logic out_free;
        logic span_end;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/msfw_ctrl.sv */
// ----------------------------------------------------------------------------
// msfw_ctrl
// Sequencer for one fill command: address setup, then one write per cycle while the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module msfw_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  msfw_pkg::t_stat     i_stat,
    output msfw_pkg::t_cmd      o_cmd,
    output logic                o_in_stall
);

    msfw_pkg::t_state r_state;
    msfw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msfw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            msfw_pkg::ST_IDLE: begin
                if (i_in_valid && i_stat.cmd_ok) begin
                    n_state = msfw_pkg::ST_MUL;
                end
            end
            msfw_pkg::ST_MUL: begin
                n_state = msfw_pkg::ST_BASE;
            end
            msfw_pkg::ST_BASE: begin
                n_state = msfw_pkg::ST_EMIT;
            end
            msfw_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.span_end) begin
                    n_state = msfw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = msfw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            msfw_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid && i_stat.cmd_ok;
            end
            msfw_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            msfw_pkg::ST_BASE: begin
                o_cmd.base = 1'b1;
            end
            msfw_pkg::ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/msfw_datapath.sv */
// ----------------------------------------------------------------------------
// msfw_datapath
// Configuration registers, command latch, row address and byte column
// counters, mask generation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msfw_datapath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_write,
    input  wire logic [msfw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [msfw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic [msfw_pkg::X_W-1:0]             i_first_x,
    input  wire logic [msfw_pkg::X_W-1:0]             i_last_x,
    input  wire logic [msfw_pkg::ROW_W-1:0]           i_top_row,
    input  wire logic [msfw_pkg::THICK_W-1:0]         i_thickness,
    input  wire logic [msfw_pkg::COLOUR_W-1:0]        i_colour,
    input  msfw_pkg::t_cmd                            i_cmd,
    output msfw_pkg::t_stat                           o_stat,
    input  wire logic                                 i_out_stall,
    output logic                                      o_out_valid,
    output logic [msfw_pkg::ADDR_W-1:0]               o_byte_address,
    output logic [7:0]                                o_bit_mask,
    output logic [7:0]                                o_byte_value,
    output logic                                      o_last_write
);

    logic [msfw_pkg::ADDR_W-1:0]   r_frame_base;
    logic [msfw_pkg::PITCH_W-1:0]  r_pitch;
    logic [msfw_pkg::X_W-1:0]      r_fx;
    logic [msfw_pkg::X_W-1:0]      r_lx;
    logic [msfw_pkg::ROW_W-1:0]    r_top;
    logic [msfw_pkg::THICK_W-1:0]  r_rows;
    logic [7:0]                    r_value;
    logic [msfw_pkg::PROD_W-1:0]   r_prod;
    logic [msfw_pkg::ADDR_W-1:0]   r_row_addr;
    logic [msfw_pkg::COL_W-1:0]    r_col;
    logic [msfw_pkg::THICK_W-1:0]  r_row_cnt;
    logic                          r_out_valid;
    logic [msfw_pkg::ADDR_W-1:0]   r_out_addr;
    logic [7:0]                    r_out_mask;
    logic [7:0]                    r_out_value;
    logic                          r_out_last;

    logic [msfw_pkg::PITCH_W:0]    pitch_sum;
    logic [msfw_pkg::STRIDE_W-1:0] stride;
    logic [msfw_pkg::THICK_W-1:0]  rows_sat;
    logic [msfw_pkg::COL_W-1:0]    first_col;
    logic [msfw_pkg::COL_W-1:0]    last_col;
    logic                          col_last;
    logic                          row_last;
    logic [2:0]                    lo_bit;
    logic [2:0]                    hi_bit;
    logic [7:0]                    mask;
    logic                          n_out_valid;

    assign pitch_sum = {1'b0, r_pitch} + 9'd7;
    assign stride    = pitch_sum[msfw_pkg::PITCH_W:3];
    assign rows_sat  = (i_thickness > msfw_pkg::MAX_THICKNESS) ? msfw_pkg::MAX_THICKNESS
                                                               : i_thickness;
    assign first_col = r_fx[msfw_pkg::X_W-1:3];
    assign last_col  = r_lx[msfw_pkg::X_W-1:3];
    assign col_last  = (r_col == last_col);
    assign row_last  = (r_row_cnt == 3'(r_rows - 3'd1));
    assign lo_bit    = (r_col == first_col) ? r_fx[2:0] : 3'd0;
    assign hi_bit    = col_last ? r_lx[2:0] : 3'd7;
    assign mask      = (msfw_pkg::BYTE_ONES >> lo_bit)
                     & (msfw_pkg::BYTE_ONES << (3'd7 - hi_bit));

    assign o_stat.cmd_ok   = (i_colour == msfw_pkg::COLOUR_CLEAR
                              || i_colour == msfw_pkg::COLOUR_SET)
                           && (i_last_x >= i_first_x)
                           && (i_thickness != 3'd0);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.span_end = col_last && row_last;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= msfw_pkg::BASE_RESET;
            r_pitch      <= msfw_pkg::PITCH_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_write) begin
                case (i_cfg_index)
                    msfw_pkg::REG_FRAME_BASE: begin
                        r_frame_base <= i_cfg_data;
                    end
                    msfw_pkg::REG_PITCH_PIXELS: begin
                        r_pitch <= i_cfg_data[msfw_pkg::PITCH_W-1:0];
                    end
                    default: begin
                        r_pitch <= r_pitch;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fx    <= i_first_x;
            r_lx    <= i_last_x;
            r_top   <= i_top_row;
            r_rows  <= rows_sat;
            r_value <= (i_colour == msfw_pkg::COLOUR_SET) ? msfw_pkg::BYTE_ONES
                                                          : msfw_pkg::BYTE_ZEROS;
        end
        if (i_cmd.mul) begin
            r_prod    <= r_top * stride;
            r_col     <= first_col;
            r_row_cnt <= 3'd0;
        end
        if (i_cmd.base) begin
            r_row_addr <= r_frame_base + 32'(r_prod);
        end
        if (i_cmd.emit) begin
            r_out_addr  <= r_row_addr + 32'(r_col);
            r_out_mask  <= mask;
            r_out_value <= r_value;
            r_out_last  <= col_last && row_last;
            if (col_last) begin
                r_col      <= first_col;
                r_row_addr <= r_row_addr + 32'(stride);
                r_row_cnt  <= r_row_cnt + 3'd1;
            end else begin
                r_col <= r_col + 4'd1;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_address = r_out_addr;
    assign o_bit_mask     = r_out_mask;
    assign o_byte_value   = r_out_value;
    assign o_last_write   = r_out_last;

endmodule

`default_nettype wire

/* rtl/mono_span_fill_writer_unit.sv */
// ----------------------------------------------------------------------------
// mono_span_fill_writer_unit
// Turns one horizontal span fill command into masked byte writes for a
// 1-bit-per-pixel framebuffer.
//
//   Channel   Direction  Handshake                Payload
//   cmd in    input      i_in_valid / o_in_stall  first_x, last_x, top_row,
//                                                 thickness, colour
//   write out output     o_out_valid / i_out_stall byte_address, bit_mask,
//                                                 byte_value, last_write
//   config    input      i_cfg_valid / o_cfg_ready index, data
//
// A command that writes nothing is taken and dropped.
// Any other command computes the first row address (one multiply, then one
// add) and then makes one write per cycle while the output is not stalled,
// one for each byte of each row.
// Output stalls hold the output register and pause the write sequencer.
// Reset is synchronous and active low; configuration returns to base 0 and
// pitch 128.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_span_fill_writer_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [msfw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [msfw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [msfw_pkg::X_W-1:0]             i_first_x,
    input  wire logic [msfw_pkg::X_W-1:0]             i_last_x,
    input  wire logic [msfw_pkg::ROW_W-1:0]           i_top_row,
    input  wire logic [msfw_pkg::THICK_W-1:0]         i_thickness,
    input  wire logic [msfw_pkg::COLOUR_W-1:0]        i_colour,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [msfw_pkg::ADDR_W-1:0]               o_byte_address,
    output logic [7:0]                                o_bit_mask,
    output logic [7:0]                                o_byte_value,
    output logic                                      o_last_write
);

    msfw_pkg::t_cmd  s_cmd;
    msfw_pkg::t_stat s_stat;

    assign o_cfg_ready = 1'b1;

    msfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd),
        .o_in_stall (o_in_stall)
    );

    msfw_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_write    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_first_x      (i_first_x),
        .i_last_x       (i_last_x),
        .i_top_row      (i_top_row),
        .i_thickness    (i_thickness),
        .i_colour       (i_colour),
        .i_cmd          (s_cmd),
        .o_stat         (s_stat),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_byte_address (o_byte_address),
        .o_bit_mask     (o_bit_mask),
        .o_byte_value   (o_byte_value),
        .o_last_write   (o_last_write)
    );

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && s_stat.cmd_ok) |=> o_in_stall)
        else $error("command accepted but sequencer did not go busy");

    a_more_writes_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_write) |-> o_in_stall)
        else $error("new command taken while a span is still being written");

    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bit_mask != 8'd0))
        else $error("write presented with an empty bit mask");

endmodule

`default_nettype wire
